/* hw/rtl/klein_pkg.sv */
// Package with the round constants, types and combinational round functions of the cipher.
`default_nettype none
package klein_pkg;

    localparam int ROUND_COUNT = 12;
    localparam int BLOCK_W     = 64;
    localparam int ROUND_W     = 8;
    localparam int ADDR_W      = 4;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [ROUND_W-1:0] t_round;
    typedef logic [ADDR_W-1:0]  t_addr;

    localparam logic [3:0] SBOX [16] = '{
        4'h7, 4'h4, 4'hA, 4'h9, 4'h1, 4'hF, 4'hB, 4'h0,
        4'hC, 4'h3, 4'h2, 4'h6, 4'h8, 4'hD, 4'hE, 4'h5
    };

    localparam logic ADDR_KEY = 1'b0;

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return {SBOX[b[7:4]], SBOX[b[3:0]]};
    endfunction

    function automatic t_block sub_all(input t_block v);
        t_block r;
        for (int k = 0; k < 16; k++) begin
            r[4*k +: 4] = SBOX[v[4*k +: 4]];
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] mix_column(input logic [31:0] c);
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] all_x;
        a0    = c[31:24];
        a1    = c[23:16];
        a2    = c[15:8];
        a3    = c[7:0];
        all_x = a0 ^ a1 ^ a2 ^ a3;
        return {a0 ^ all_x ^ xtime(a0 ^ a1),
                a1 ^ all_x ^ xtime(a1 ^ a2),
                a2 ^ all_x ^ xtime(a2 ^ a3),
                a3 ^ all_x ^ xtime(a3 ^ a0)};
    endfunction

    function automatic t_block round_fn(input t_block s, input t_block k);
        t_block t;
        t = sub_all(s ^ k);
        t = {t[47:0], t[63:48]};
        return {mix_column(t[63:32]), mix_column(t[31:0])};
    endfunction

    function automatic t_block next_key(input t_block k, input t_round rnd);
        return {k[23:16],
                k[15:8],
                k[7:0] ^ rnd,
                k[31:24],
                k[55:48] ^ k[23:16],
                sub_byte(k[47:40] ^ k[15:8]),
                sub_byte(k[39:32] ^ k[7:0]),
                k[63:56] ^ k[31:24]};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/klein_round.sv */
// One pipeline stage that performs a full cipher round and the matching key schedule step.
`default_nettype none
module klein_round (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  klein_pkg::t_block i_state,
    input  wire  klein_pkg::t_block i_key,
    input  wire  klein_pkg::t_round i_round,
    output logic                  o_valid,
    input  wire                   i_ready,
    output klein_pkg::t_block     o_state,
    output klein_pkg::t_block     o_key
);

    logic              r_valid;
    klein_pkg::t_block r_state;
    klein_pkg::t_block r_key;
    klein_pkg::t_block n_state;
    klein_pkg::t_block n_key;

    always_comb begin
        n_state = klein_pkg::round_fn(i_state, i_key);
        n_key   = klein_pkg::next_key(i_key, i_round);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule
`default_nettype wire

/* hw/rtl/klein_apb.sv */
// Configuration register file holding the master key behind an APB-style port.
`default_nettype none
module klein_apb (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  klein_pkg::t_addr paddr,
    input  wire  klein_pkg::t_block pwdata,
    output klein_pkg::t_block     prdata,
    output logic                  pready,
    output klein_pkg::t_block     o_key
);

    klein_pkg::t_block r_key;
    logic              w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite
                     && (paddr[klein_pkg::ADDR_W-1] == klein_pkg::ADDR_KEY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (w_write) begin
            r_key <= pwdata;
        end
    end

    always_comb begin
        if (paddr[klein_pkg::ADDR_W-1] == klein_pkg::ADDR_KEY) begin
            prdata = r_key;
        end else begin
            prdata = '0;
        end
    end

    assign o_key = r_key;

endmodule
`default_nettype wire

/* hw/rtl/klein64_block_encrypt_core.sv */
// Throughput: one block per cycle unless i_ready holds the output back; each round is one
// register stage, then an output stage applies the final key. Every stage loads whenever
// it is empty or its beat moves on.
// Reset: synchronous, active low; it empties the pipeline and clears the key to zero.
`default_nettype none
module klein64_block_encrypt_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  klein_pkg::t_addr  paddr,
    input  wire  klein_pkg::t_block pwdata,
    output klein_pkg::t_block      prdata,
    output logic                   pready,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire  klein_pkg::t_block i_plain_block,
    output logic                   o_valid,
    input  wire                    i_ready,
    output klein_pkg::t_block      o_cipher_block
);

    localparam int NR = klein_pkg::ROUND_COUNT;

    klein_pkg::t_block w_key;
    logic              w_valid [NR+1];
    logic              w_ready [NR+1];
    klein_pkg::t_block w_state [NR+1];
    klein_pkg::t_block w_rkey  [NR+1];

    logic              r_out_valid;
    klein_pkg::t_block r_cipher;

    klein_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key)
    );

    assign w_valid[0] = i_valid;
    assign w_state[0] = i_plain_block;
    assign w_rkey[0]  = w_key;
    assign o_ready    = w_ready[0];

    for (genvar g = 0; g < NR; g++) begin : g_round
        klein_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_state (w_state[g]),
            .i_key   (w_rkey[g]),
            .i_round (klein_pkg::t_round'(g + 1)),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_state (w_state[g+1]),
            .o_key   (w_rkey[g+1])
        );
    end

    assign w_ready[NR] = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[NR]) begin
            r_out_valid <= w_valid[NR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[NR] && w_valid[NR]) begin
            r_cipher <= w_state[NR] ^ w_rkey[NR];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cipher_block = r_cipher;

endmodule
`default_nettype wire

/* sim/klein64_cipher_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts KLEIN-64 ciphertexts from observed key writes and compares output beats.
module klein64_cipher_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  klein_pkg::t_addr     paddr,
    input  klein_pkg::t_block    pwdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  klein_pkg::t_block    i_plain_block,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  klein_pkg::t_block    i_cipher_block,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'h7, 4'h4, 4'hA, 4'h9, 4'h1, 4'hF, 4'hB, 4'h0,
        4'hC, 4'h3, 4'h2, 4'h6, 4'h8, 4'hD, 4'hE, 4'h5
    };
    localparam klein_pkg::t_addr KEY_ADDR = klein_pkg::t_addr'(klein_pkg::ADDR_KEY);

    klein_pkg::t_block key_shadow;
    klein_pkg::t_block ciphertext_due [$];
    int                mismatches;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        logic [7:0] r;
        r = {b[6:0], 1'b0};
        if (b[7]) begin
            r = r ^ 8'h1B;
        end
        return r;
    endfunction

    function automatic logic [63:0] sub_nibbles(input logic [63:0] v);
        logic [63:0] r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = NIBBLE_SUB[v[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [7:0]  a [4];
        logic [7:0]  total;
        logic [31:0] r;
        for (int j = 0; j < 4; j++) begin
            a[j] = w[31-8*j -: 8];
        end
        total = a[0] ^ a[1] ^ a[2] ^ a[3];
        for (int j = 0; j < 4; j++) begin
            r[31-8*j -: 8] = a[j] ^ total ^ gf_double(a[j] ^ a[(j+1)%4]);
        end
        return r;
    endfunction

    function automatic logic [63:0] advance_key(input logic [63:0] k, input logic [7:0] rnd);
        logic [7:0]  kb [8];
        logic [7:0]  nb [8];
        logic [7:0]  t5;
        logic [7:0]  t6;
        logic [63:0] r;
        for (int j = 0; j < 8; j++) begin
            kb[j] = k[63-8*j -: 8];
        end
        t5    = kb[2] ^ kb[6];
        t6    = kb[3] ^ kb[7];
        nb[0] = kb[5];
        nb[1] = kb[6];
        nb[2] = kb[7] ^ rnd;
        nb[3] = kb[4];
        nb[4] = kb[1] ^ kb[5];
        nb[5] = {NIBBLE_SUB[t5[7:4]], NIBBLE_SUB[t5[3:0]]};
        nb[6] = {NIBBLE_SUB[t6[7:4]], NIBBLE_SUB[t6[3:0]]};
        nb[7] = kb[0] ^ kb[4];
        for (int j = 0; j < 8; j++) begin
            r[63-8*j -: 8] = nb[j];
        end
        return r;
    endfunction

    function automatic logic [63:0] klein64_encrypt(input logic [63:0] plain,
                                                    input logic [63:0] key);
        logic [63:0] s;
        logic [63:0] rk;
        logic [63:0] t;
        s  = plain;
        rk = key;
        for (int rnd = 1; rnd <= klein_pkg::ROUND_COUNT; rnd++) begin
            t  = sub_nibbles(s ^ rk);
            t  = {t[47:0], t[63:48]};
            s  = {mix_word(t[63:32]), mix_word(t[31:0])};
            rk = advance_key(rk, klein_pkg::t_round'(rnd));
        end
        return s ^ rk;
    endfunction

    always @(posedge i_clk) begin
        klein_pkg::t_block due;
        if (!i_rst_n) begin
            key_shadow = '0;
            ciphertext_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                ciphertext_due.push_back(klein64_encrypt(i_plain_block, key_shadow));
            end
            if (psel && penable && pwrite && pready && paddr == KEY_ADDR) begin
                key_shadow = pwdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (ciphertext_due.size() == 0) begin
                    $display("%0t: cipher_block beat with none expected: expected none, got %h",
                             $time, i_cipher_block);
                    mismatches++;
                end else begin
                    due = ciphertext_due.pop_front();
                    if (i_cipher_block !== due) begin
                        $display("%0t: cipher_block mismatch: expected %h, got %h",
                                 $time, due, i_cipher_block);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= ciphertext_due.size();
    end

endmodule

/* sim/klein64_block_encrypt_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top that drives key writes and plaintext beats into the KLEIN-64 core.
module klein64_block_encrypt_core_tb;

    localparam int                LATENCY     = klein_pkg::ROUND_COUNT + 1;
    localparam int                CYCLE_LIMIT = 400000;
    localparam int                PER_KEY     = 250;
    localparam klein_pkg::t_addr  KEY_ADDR    = klein_pkg::t_addr'(klein_pkg::ADDR_KEY);
    localparam klein_pkg::t_addr  SPARE_ADDR  = 4'd8;
    localparam logic [63:0]       DIR_KEYS [5] = '{
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0000
    };
    localparam logic [63:0]       DIR_PLAINS [4] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    klein_pkg::t_addr  paddr         = '0;
    klein_pkg::t_block pwdata        = '0;
    logic              i_valid       = 1'b0;
    klein_pkg::t_block i_plain_block = '0;
    logic              i_ready       = 1'b0;
    klein_pkg::t_block prdata;
    logic              pready;
    logic              o_ready;
    logic              o_valid;
    klein_pkg::t_block o_cipher_block;

    int fail_count;
    int blocks_in_flight;
    int cycle_count   = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 88;

    klein64_block_encrypt_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_plain_block  (i_plain_block),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cipher_block (o_cipher_block)
    );

    klein64_cipher_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_plain_block  (i_plain_block),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_cipher_block (o_cipher_block),
        .o_fail_count   (fail_count),
        .o_pending      (blocks_in_flight)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_ready     <= ($urandom_range(99) >= recv_idle_pct);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input klein_pkg::t_addr addr, input klein_pkg::t_block value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_block(input klein_pkg::t_block plain);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_plain_block <= plain;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (blocks_in_flight != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The key left by reset is zero.
        send_block(DIR_PLAINS[0]);
        send_block(DIR_PLAINS[1]);
        drain();
        for (int k = 0; k < 5; k++) begin
            write_reg(KEY_ADDR, DIR_KEYS[k]);
            if (k == 2) begin
                write_reg(SPARE_ADDR, {$urandom, $urandom});
            end
            for (int p = 0; p < 4; p++) begin
                send_block(DIR_PLAINS[p] ^ DIR_KEYS[(k + p) % 5]);
            end
            drain();
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 10 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                write_reg(KEY_ADDR, {$urandom, $urandom});
                repeat (PER_KEY) send_block({$urandom, $urandom});
                drain();
            end
        end

        if (fail_count == 0 && blocks_in_flight == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
